@@ design/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear-probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Default number of slots
  localparam int TABLE_SIZE_DEF = 16;

  // Field widths
  localparam int VALUE_W  = 31;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic                load_in;    // latch request, start home-slot calc
    logic                set_home;   // ptr = home, steps = 0
    logic                rd_en;      // read slot at ptr
    logic                advance;    // ptr = next(ptr), steps++
    logic                start_comp; // ptr = next(ptr), steps = 1
    logic                wr_insert;  // write new entry at ptr
    logic                wr_clear;   // write empty word at ptr
    logic                wr_move;    // write last read entry at hole
    logic                set_hole;   // hole = ptr
    logic                set_slot;   // result slot = ptr
    logic                cnt_inc;
    logic                cnt_dec;
    logic                out_load;   // load output register
    logic [STATUS_W-1:0] out_status;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic            mod_done;  // home slot ready
    logic            rd_valid;  // read slot occupied
    logic            rd_match;  // read slot value equals request value
    logic            stays;     // read entry's home lies in (hole, ptr]
    logic            last_step; // steps at TABLE_SIZE-1
    logic            ptr_last;  // ptr at last slot
    logic            full;      // count at TABLE_SIZE
    logic            out_busy;  // output register holds an untaken result
    logic [OP_W-1:0] op;
  } sts_t;

endpackage

@@ design/lpht_ram.sv @@
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/lpht_datapath.sv @@
// ----------------------------------------------------------------------------
// lpht_datapath
// Request registers, home-slot modulo unit, probe pointer, slot RAM,
// entry counter and output register of the hash table.
// ----------------------------------------------------------------------------
module lpht_datapath #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lpht_pkg::cmd_t                   cmd,
  output lpht_pkg::sts_t                   sts,
  input  logic [lpht_pkg::OP_W-1:0]        in_op,
  input  logic [lpht_pkg::VALUE_W-1:0]     in_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [lpht_pkg::STATUS_W-1:0]    out_status,
  output logic [lpht_pkg::SLOT_W-1:0]      out_slot,
  output logic [lpht_pkg::COUNT_W-1:0]     out_count
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int VW = lpht_pkg::VALUE_W;
  // RAM word: {valid, home, value}
  localparam int WW = VW + IW + 1;
  localparam bit POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_SIZE);
  // Reciprocal of TABLE_SIZE, exact floor quotient for any VW-bit value
  localparam int          MOD_SH = VW + IW;
  localparam logic [31:0] RECIP  =
    32'(((64'd1 << MOD_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
  localparam logic [IW-1:0] NLO = IW'(TABLE_SIZE);

  logic [VW-1:0]                     val_r;
  logic [lpht_pkg::OP_W-1:0]         op_r;
  logic [IW-1:0]                     home_r;
  logic [IW-1:0]                     ptr_r;
  logic [IW-1:0]                     steps_r;
  logic [IW-1:0]                     hole_r;
  logic [IW-1:0]                     slot_r;
  logic [CW-1:0]                     cnt_r;
  logic [IW-1:0]                     mod_quo_r;
  logic                              mod_phase_r;
  logic                              mod_busy_r;
  logic                              out_valid_r;
  logic [lpht_pkg::STATUS_W-1:0]     out_status_r;
  logic [lpht_pkg::SLOT_W-1:0]       out_slot_r;
  logic [lpht_pkg::COUNT_W-1:0]      out_count_r;

  logic [IW-1:0]     next_ptr;
  logic [VW+32-1:0]  mod_prod;
  logic [IW-1:0]     mod_home;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [WW-1:0]     ram_wdata;
  logic [WW-1:0]     ram_rdata;
  logic [IW-1:0]     rd_home;
  logic              stays;
  logic [31:0]       slot_ext;
  logic [31:0]       cnt_ext;

  // Wrapping slot increment
  assign next_ptr = (ptr_r == LAST) ? '0 : ptr_r + IW'(1);

  // Modulo by reciprocal multiply: low quotient bits first, then the
  // remainder from the low value bits (it always fits in IW bits)
  assign mod_prod = (VW + 32)'(val_r) * (VW + 32)'(RECIP);
  assign mod_home = val_r[IW-1:0] - mod_quo_r * NLO;

  // Request and modulo unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_busy_r  <= 1'b0;
      mod_phase_r <= 1'b0;
    end else if (cmd.load_in) begin
      val_r       <= in_value;
      op_r        <= in_op;
      mod_phase_r <= 1'b0;
      if (POW2) begin
        home_r     <= in_value[IW-1:0];
        mod_busy_r <= 1'b0;
      end else begin
        mod_busy_r <= 1'b1;
      end
    end else if (mod_busy_r) begin
      if (!mod_phase_r) begin
        mod_quo_r   <= mod_prod[MOD_SH +: IW];
        mod_phase_r <= 1'b1;
      end else begin
        home_r      <= mod_home;
        mod_busy_r  <= 1'b0;
        mod_phase_r <= 1'b0;
      end
    end
  end

  // Probe pointer, step count, hole and result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      if (cmd.set_home) begin
        ptr_r   <= home_r;
        steps_r <= '0;
      end else if (cmd.start_comp) begin
        ptr_r   <= next_ptr;
        steps_r <= IW'(1);
      end else if (cmd.advance) begin
        ptr_r   <= next_ptr;
        steps_r <= steps_r + IW'(1);
      end
      if (cmd.set_hole) begin
        hole_r <= ptr_r;
      end
      if (cmd.load_in) begin
        slot_r <= '0;
      end else if (cmd.set_slot) begin
        slot_r <= ptr_r;
      end
    end
  end

  // Entry counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.cnt_dec && (cnt_r != '0)) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // Slot RAM write mux
  always_comb begin
    ram_we    = cmd.wr_insert | cmd.wr_clear | cmd.wr_move;
    ram_waddr = ptr_r;
    ram_wdata = '0;
    if (cmd.wr_insert) begin
      ram_wdata = {1'b1, home_r, val_r};
    end else if (cmd.wr_move) begin
      ram_waddr = hole_r;
      ram_wdata = ram_rdata;
    end
  end

  lpht_ram #(
    .WIDTH (WW),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // Entry stays put if its home lies cyclically in (hole, ptr]
  assign rd_home = ram_rdata[VW +: IW];
  always_comb begin
    if (hole_r <= ptr_r) begin
      stays = (hole_r < rd_home) && (rd_home <= ptr_r);
    end else begin
      stays = (hole_r < rd_home) || (rd_home <= ptr_r);
    end
  end

  // Output register
  assign slot_ext = 32'(slot_r);
  assign cnt_ext  = 32'(cnt_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r  <= 1'b1;
      out_status_r <= cmd.out_status;
      out_slot_r   <= slot_ext[lpht_pkg::SLOT_W-1:0];
      out_count_r  <= cnt_ext[lpht_pkg::COUNT_W-1:0];
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_count  = out_count_r;

  // Status to controller
  always_comb begin
    sts.mod_done  = !mod_busy_r;
    sts.rd_valid  = ram_rdata[WW-1];
    sts.rd_match  = ram_rdata[VW-1:0] == val_r;
    sts.stays     = stays;
    sts.last_step = steps_r == LAST;
    sts.ptr_last  = ptr_r == LAST;
    sts.full      = cnt_r >= FULL_CNT;
    sts.out_busy  = out_valid_r && !out_ready;
    sts.op        = op_r;
  end

endmodule

@@ design/lpht_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller state machine: clearing pass, probe walk for insert, search
// and delete, backward-shift compaction and result hand-off.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t cmd
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_HASH   = 9'b000000100,
    S_READ   = 9'b000001000,
    S_CHECK  = 9'b000010000,
    S_CREAD  = 9'b000100000,
    S_CCHECK = 9'b001000000,
    S_CMOVE  = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [lpht_pkg::STATUS_W-1:0] res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      res_r   <= lpht_pkg::ST_NOT_FOUND;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd            = '0;
    cmd.out_status = res_r;
    case (state_r)
      // Empty every slot after reset
      S_CLEAR: begin
        cmd.wr_clear = 1'b1;
        cmd.advance  = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_HASH;
        end
      end
      // Wait for home slot, then dispatch on op
      S_HASH: begin
        if (sts.mod_done) begin
          case (sts.op)
            lpht_pkg::OP_INSERT: begin
              if (sts.full) begin
                res_nxt   = lpht_pkg::ST_FULL;
                state_nxt = S_RESP;
              end else begin
                cmd.set_home = 1'b1;
                state_nxt    = S_READ;
              end
            end
            lpht_pkg::OP_SEARCH, lpht_pkg::OP_DELETE: begin
              cmd.set_home = 1'b1;
              state_nxt    = S_READ;
            end
            default: begin
              res_nxt   = lpht_pkg::ST_NOT_FOUND;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CHECK;
      end
      // Probe one slot
      S_CHECK: begin
        if (sts.op == lpht_pkg::OP_INSERT) begin
          if (!sts.rd_valid) begin
            cmd.wr_insert = 1'b1;
            cmd.cnt_inc   = 1'b1;
            cmd.set_slot  = 1'b1;
            res_nxt       = lpht_pkg::ST_INSERTED;
            state_nxt     = S_RESP;
          end else if (sts.last_step) begin
            res_nxt   = lpht_pkg::ST_FULL;
            state_nxt = S_RESP;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_READ;
          end
        end else if (!sts.rd_valid) begin
          res_nxt   = lpht_pkg::ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else if (sts.rd_match) begin
          cmd.set_slot = 1'b1;
          if (sts.op == lpht_pkg::OP_SEARCH) begin
            res_nxt   = lpht_pkg::ST_FOUND;
            state_nxt = S_RESP;
          end else begin
            cmd.wr_clear   = 1'b1;
            cmd.set_hole   = 1'b1;
            cmd.cnt_dec    = 1'b1;
            cmd.start_comp = 1'b1;
            res_nxt        = lpht_pkg::ST_DELETED;
            state_nxt      = S_CREAD;
          end
        end else if (sts.last_step) begin
          res_nxt   = lpht_pkg::ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_CREAD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CCHECK;
      end
      // Compaction: pull entry back into the hole unless its home forbids
      S_CCHECK: begin
        if (!sts.rd_valid) begin
          state_nxt = S_RESP;
        end else if (!sts.stays) begin
          cmd.wr_move = 1'b1;
          state_nxt   = S_CMOVE;
        end else if (sts.last_step) begin
          state_nxt = S_RESP;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_CREAD;
        end
      end
      // Vacate the moved entry's old slot, it becomes the hole
      S_CMOVE: begin
        cmd.wr_clear = 1'b1;
        cmd.set_hole = 1'b1;
        if (sts.last_step) begin
          state_nxt = S_RESP;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_CREAD;
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/linear_probe_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressed hash table with linear probing, streaming interface.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the block clears the slot
// RAM before in_tready rises. A request is then accepted, its home slot is
// calculated (taken from the low value bits when TABLE_SIZE is a power of
// two, otherwise in the reciprocal-multiply modulo unit), slots are probed
// through the registered RAM read port (up to TABLE_SIZE probes), and for
// delete the cluster entries are walked in compaction (up to TABLE_SIZE-1),
// before the output register is loaded. A request that needs no probe
// (insert into a full table, unused op) goes straight to the output
// register. A result waiting in the output register does not block
// acceptance of the next request; that request's result is held back until
// the waiting one has been taken.
module linear_probe_hash_table_top #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] item_value, [31] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] slot_index, [8:4] entry_count
  output logic [2:0]  out_tuser   // [2:0] status
);

  lpht_pkg::cmd_t                   cmd;
  lpht_pkg::sts_t                   sts;
  logic [lpht_pkg::SLOT_W-1:0]      slot_index;
  logic [lpht_pkg::COUNT_W-1:0]     entry_count;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpht_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_value   (in_tdata[lpht_pkg::VALUE_W-1:0]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_slot   (slot_index),
    .out_count  (entry_count)
  );

  // Pack result payload
  assign out_tdata = {7'd0, entry_count, slot_index};

endmodule

@@ design/lpht_checker.sv @@
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser
);

  localparam logic [4:0] FULL_CNT = 5'(TABLE_SIZE);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Only defined status codes are reported
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == lpht_pkg::ST_INSERTED) || (out_tuser == lpht_pkg::ST_FOUND)
                || (out_tuser == lpht_pkg::ST_DELETED) || (out_tuser == lpht_pkg::ST_NOT_FOUND)
                || (out_tuser == lpht_pkg::ST_FULL))
    else $error("undefined status code");

  // Failed requests report slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == lpht_pkg::ST_NOT_FOUND) || (out_tuser == lpht_pkg::ST_FULL))
    |-> out_tdata[3:0] == 4'd0)
    else $error("slot index not zero on failed request");

  // Table full means every slot counted
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == lpht_pkg::ST_FULL) |-> out_tdata[8:4] == FULL_CNT)
    else $error("table full with wrong entry count");

  // Clearing pass after reset: no transaction either side
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("handshake active right after reset");

endmodule

bind linear_probe_hash_table_top lpht_checker #(
  .TABLE_SIZE (TABLE_SIZE)
) u_lpht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ dv/linear_probe_hash_table_top_tb.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_tb
// Self-checking testbench for the linear-probing hash table. A shadow copy of
// the table predicts each reply from accepted requests; replies are checked
// in order under random idling on both stream sides.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TS            = lpht_pkg::TABLE_SIZE_DEF;
  localparam int VW            = lpht_pkg::VALUE_W;
  localparam int OPW           = lpht_pkg::OP_W;
  localparam int STW           = lpht_pkg::STATUS_W;
  localparam int SW            = lpht_pkg::SLOT_W;
  localparam int CNTW          = lpht_pkg::COUNT_W;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int TAIL_ITEMS    = 200;
  localparam int DRAIN_CYCLES  = 120;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [STW-1:0]  status;
    logic [SW-1:0]   slot;
    logic [CNTW-1:0] count;
  } reply_t;

  // Shadow table: predicts replies and checks them in arrival order
  class hash_table_shadow;
    logic [VW-1:0] slot_val[TS];
    bit            slot_used[TS];
    int            occupancy;
    reply_t        owed_replies[$];
    int            errors;
    int            tally[5];

    // First slot holding v on the probe walk, or -1
    function int probe_for(logic [VW-1:0] v);
      int s;
      s = v % TS;
      for (int n = 0; n < TS; n++) begin
        if (!slot_used[s]) return -1;
        if (slot_val[s] == v) return s;
        s = (s + 1) % TS;
      end
      return -1;
    endfunction

    // Picks a stored value into v; v is left alone when the table is empty
    function bit stored_value(inout logic [VW-1:0] v);
      int used_idx[$];
      for (int i = 0; i < TS; i++)
        if (slot_used[i]) used_idx.push_back(i);
      if (used_idx.size() == 0) return 0;
      v = slot_val[used_idx[$urandom_range(0, used_idx.size() - 1)]];
      return 1;
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    function void note_request(logic [OPW-1:0] op, logic [VW-1:0] v);
      reply_t r;
      int     s;
      int     j;
      int     k;
      int     hole;
      bit     keep;
      r.status = lpht_pkg::ST_NOT_FOUND;
      r.slot   = '0;
      case (op)
        lpht_pkg::OP_INSERT: begin
          if (occupancy >= TS) begin
            r.status = lpht_pkg::ST_FULL;
          end else begin
            s = v % TS;
            for (int n = 0; n < TS; n++) begin
              if (!slot_used[s]) begin
                slot_val[s]  = v;
                slot_used[s] = 1'b1;
                occupancy++;
                r.status = lpht_pkg::ST_INSERTED;
                r.slot   = SW'(s);
                break;
              end
              s = (s + 1) % TS;
            end
            if (r.status != lpht_pkg::ST_INSERTED) r.status = lpht_pkg::ST_FULL;
          end
        end
        lpht_pkg::OP_SEARCH: begin
          s = probe_for(v);
          if (s >= 0) begin
            r.status = lpht_pkg::ST_FOUND;
            r.slot   = SW'(s);
          end
        end
        lpht_pkg::OP_DELETE: begin
          s = probe_for(v);
          if (s >= 0) begin
            // empty the slot, then pull back cluster members whose home
            // does not lie cyclically in (hole, j]
            hole = s;
            j    = s;
            slot_used[s] = 1'b0;
            for (int n = 1; n < TS; n++) begin
              j = (j + 1) % TS;
              if (!slot_used[j]) break;
              k = slot_val[j] % TS;
              if (hole <= j) keep = (hole < k) && (k <= j);
              else           keep = (hole < k) || (k <= j);
              if (!keep) begin
                slot_val[hole]  = slot_val[j];
                slot_used[hole] = 1'b1;
                slot_used[j]    = 1'b0;
                hole = j;
              end
            end
            if (occupancy > 0) occupancy--;
            r.status = lpht_pkg::ST_DELETED;
            r.slot   = SW'(s);
          end
        end
        default: ;
      endcase
      r.count = CNTW'(occupancy);
      owed_replies.push_back(r);
      tally[r.status]++;
    endfunction

    function void check_result(logic [STW-1:0] st, logic [SW-1:0] sl,
                               logic [CNTW-1:0] cnt);
      reply_t e;
      if (owed_replies.size() == 0) begin
        $error("reply with no request pending: status=%0d slot=%0d count=%0d",
               st, sl, cnt);
        errors++;
        return;
      end
      e = owed_replies.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (sl !== e.slot) begin
        $error("slot_index: expected %0d, got %0d", e.slot, sl);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("entry_count: expected %0d, got %0d", e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [30:0] item_value, [31] zero
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [3:0] slot_index, [8:4] entry_count
  logic [2:0]  out_tuser;  // [2:0] status

  hash_table_shadow shadow = new();
  bit               steady_tail;
  int               idle_cycles;
  int               stall_left;

  linear_probe_hash_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Reply side: random backpressure bursts, none in the tail
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (!steady_tail && rst_n && $urandom_range(0, 9) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_tready = rst_n;
      end
    end
  end

  // Check each reply transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      shadow.check_result(out_tuser, out_tdata[3:0], out_tdata[8:4]);
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("linear_probe_hash_table_top_tb: FAIL");
      $finish;
    end
  end

  // One request transaction, with an optional idle burst in front
  task automatic push_request(logic [OPW-1:0] op, logic [VW-1:0] v);
    int gap;
    gap = 0;
    if (!steady_tail && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 9);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {1'b0, v};
    do @(posedge clk); while (!in_tready);
    shadow.note_request(op, v);
  endtask

  // Keys clustered near the wrap point, plus high-bit and full-range values
  function automatic logic [VW-1:0] pick_key();
    int          r;
    logic [3:0]  home;
    r    = $urandom_range(0, 9);
    home = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(12, 15));
    if (r < 6)      return VW'(($urandom_range(0, 3) << 4) | home);
    else if (r < 8) return 31'h7FFF_FFC0 + VW'($urandom_range(0, 63));
    else            return VW'($urandom());
  endfunction

  task automatic run_directed();
    // empty table misses
    push_request(lpht_pkg::OP_SEARCH, 31'd0);
    push_request(lpht_pkg::OP_DELETE, 31'd5);
    // extremes, wraparound and a duplicate
    push_request(lpht_pkg::OP_INSERT, 31'd0);
    push_request(lpht_pkg::OP_INSERT, 31'h7FFF_FFFF);
    push_request(lpht_pkg::OP_INSERT, 31'd31);
    push_request(lpht_pkg::OP_INSERT, 31'd16);
    push_request(lpht_pkg::OP_INSERT, 31'd0);
    push_request(lpht_pkg::OP_SEARCH, 31'd31);
    push_request(lpht_pkg::OP_SEARCH, 31'd0);
    push_request(lpht_pkg::OP_SEARCH, 31'd47);
    // delete at the last slot: compaction crosses the wrap
    push_request(lpht_pkg::OP_DELETE, 31'h7FFF_FFFF);
    push_request(lpht_pkg::OP_DELETE, 31'd0);
    push_request(lpht_pkg::OP_SEARCH, 31'd0);
    push_request(OP_UNUSED, 31'h2AAA_AAAA);
    // fill up, then insert into a full table and search it end to end
    for (int i = 0; i < 13; i++) push_request(lpht_pkg::OP_INSERT, VW'(i * 17 + 3));
    push_request(lpht_pkg::OP_INSERT, 31'd99);
    push_request(lpht_pkg::OP_SEARCH, 31'h5555_5555);
  endtask

  task automatic run_random();
    int             mode;
    int             r;
    int             ins_cut;
    int             srch_cut;
    logic [OPW-1:0] op;
    logic [VW-1:0]  v;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - TAIL_ITEMS) steady_tail = 1'b1;
      // blocks of 60 alternate fill-heavy, drain-heavy and mixed traffic
      mode = (i / 60) % 3;
      case (mode)
        0: begin
          ins_cut  = 70;
          srch_cut = 85;
        end
        1: begin
          ins_cut  = 20;
          srch_cut = 40;
        end
        default: begin
          ins_cut  = 40;
          srch_cut = 70;
        end
      endcase
      r = $urandom_range(0, 99);
      if (r < 2)             op = OP_UNUSED;
      else if (r < ins_cut)  op = lpht_pkg::OP_INSERT;
      else if (r < srch_cut) op = lpht_pkg::OP_SEARCH;
      else                   op = lpht_pkg::OP_DELETE;
      v = pick_key();
      if ((op == lpht_pkg::OP_SEARCH || op == lpht_pkg::OP_DELETE) &&
          $urandom_range(0, 99) < 70)
        void'(shadow.stored_value(v));
      push_request(op, v);
    end
  endtask

  // Main sequence
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    steady_tail = 1'b0;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_random();
    @(negedge clk);
    in_tvalid = 1'b0;

    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserted, %0d found, %0d deleted, %0d not found, %0d full",
             shadow.tally[lpht_pkg::ST_INSERTED], shadow.tally[lpht_pkg::ST_FOUND],
             shadow.tally[lpht_pkg::ST_DELETED], shadow.tally[lpht_pkg::ST_NOT_FOUND],
             shadow.tally[lpht_pkg::ST_FULL]);
    $display("keys clustered across the wrap, duplicates, unused op code, random stalls");
    if (shadow.errors == 0) begin
      $display("linear_probe_hash_table_top_tb: PASS");
    end else begin
      $display("linear_probe_hash_table_top_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/lpht_pkg.sv
design/lpht_ram.sv
design/lpht_datapath.sv
design/lpht_ctrl.sv
design/linear_probe_hash_table_top.sv
design/lpht_checker.sv
dv/linear_probe_hash_table_top_tb.sv
